// File: src/grc_pkg.sv
// grc_pkg: constants, types, command codes and trig helpers for the grid ray caster.
// Used by the controller, the datapath, the divider and the port checker.
`default_nettype none

package grc_pkg;

  localparam int NUM_RAYS      = 60;
  localparam int MAX_CROSSINGS = 8;
  localparam int MAP_SIDE      = 8;
  localparam int VIEW_HEIGHT   = 320;

  localparam int TILE        = 16384;
  localparam int NO_HIT_DIST = 25600000;
  localparam int AXIS_EPS    = 16;
  localparam int TAN_LIMIT   = 1048575;
  localparam int HALF_FOV    = 30;
  localparam int HEIGHT_NUM  = 64 * VIEW_HEIGHT * 256;

  localparam int PW  = 27;   // probe, step and distance width, Q.14 signed
  localparam int TW  = 22;   // tangent width, Q.14 signed
  localparam int PRW = 50;   // product width
  localparam int DVW = 30;   // dividend and quotient width
  localparam int DSW = 25;   // divisor width
  localparam int CW  = $clog2(MAX_CROSSINGS + 1);
  localparam int RW  = 6;    // ray index width

  typedef logic signed [PW-1:0]  pos_t;
  typedef logic signed [TW-1:0]  tan_t;
  typedef logic signed [PRW-1:0] prod_t;
  typedef logic signed [15:0]    trig_t;

  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_TRIG,
    CMD_DIV_TAN,
    CMD_SAVE_TAN,
    CMD_DIV_COT,
    CMD_SAVE_COT,
    CMD_VINIT,
    CMD_VMUL_POS,
    CMD_VSET_POS,
    CMD_VMUL_ADV,
    CMD_VSET_ADV,
    CMD_HINIT,
    CMD_HMUL_POS,
    CMD_HSET_POS,
    CMD_HMUL_ADV,
    CMD_HSET_ADV,
    CMD_STEP,
    CMD_DMUL_C,
    CMD_DMUL_S,
    CMD_DSET,
    CMD_SELECT,
    CMD_CMUL,
    CMD_CSET,
    CMD_DIV_H,
    CMD_SET_H,
    CMD_EMIT
  } cmd_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_VERT,
    PH_HORZ
  } phase_t;

  typedef struct packed {
    cmd_t cmd;
  } ctl_t;

  typedef struct packed {
    logic v_en;
    logic h_en;
    logic wall;
    logic walk_done;
    logic horz;
    logic div_done;
    logic cdist_pos;
    logic last_ray;
  } stat_t;

  // round(16384*sin(d)) for d = 0..90
  localparam logic [14:0] SIN_Q [0:90] = '{
    15'd0,     15'd286,   15'd572,   15'd857,   15'd1143,  15'd1428,  15'd1713,
    15'd1997,  15'd2280,  15'd2563,  15'd2845,  15'd3126,  15'd3406,  15'd3686,
    15'd3964,  15'd4240,  15'd4516,  15'd4790,  15'd5063,  15'd5334,  15'd5604,
    15'd5872,  15'd6138,  15'd6402,  15'd6664,  15'd6924,  15'd7182,  15'd7438,
    15'd7692,  15'd7943,  15'd8192,  15'd8438,  15'd8682,  15'd8923,  15'd9162,
    15'd9397,  15'd9630,  15'd9860,  15'd10087, 15'd10311, 15'd10531, 15'd10749,
    15'd10963, 15'd11174, 15'd11381, 15'd11585, 15'd11786, 15'd11982, 15'd12176,
    15'd12365, 15'd12551, 15'd12733, 15'd12911, 15'd13085, 15'd13255, 15'd13421,
    15'd13583, 15'd13741, 15'd13894, 15'd14044, 15'd14189, 15'd14330, 15'd14466,
    15'd14598, 15'd14726, 15'd14849, 15'd14968, 15'd15082, 15'd15191, 15'd15296,
    15'd15396, 15'd15491, 15'd15582, 15'd15668, 15'd15749, 15'd15826, 15'd15897,
    15'd15964, 15'd16026, 15'd16083, 15'd16135, 15'd16182, 15'd16225, 15'd16262,
    15'd16294, 15'd16322, 15'd16344, 15'd16362, 15'd16374, 15'd16382, 15'd16384
  };

  function automatic trig_t sin_q14(input logic [8:0] a);
    logic [6:0] idx;
    logic       neg;
    trig_t      mag;
    if (a <= 9'd90) begin
      idx = 7'(a);
      neg = 1'b0;
    end else if (a <= 9'd180) begin
      idx = 7'(9'd180 - a);
      neg = 1'b0;
    end else if (a <= 9'd270) begin
      idx = 7'(a - 9'd180);
      neg = 1'b1;
    end else begin
      idx = 7'(9'd360 - a);
      neg = 1'b1;
    end
    mag = $signed({1'b0, SIN_Q[idx]});
    return neg ? -mag : mag;
  endfunction

  function automatic trig_t cos_q14(input logic [8:0] a);
    logic [9:0] s;
    s = {1'b0, a} + 10'd90;
    if (s >= 10'd360) s = s - 10'd360;
    return sin_q14(s[8:0]);
  endfunction

  // floor((p + 8192) / 16384), kept to the probe width
  function automatic pos_t q14_round(input prod_t p);
    prod_t t;
    t = p + prod_t'(8192);
    return t[PW+13:14];
  endfunction

endpackage

`default_nettype wire

// File: src/grc_div.sv
// grc_div: restoring unsigned divider, two quotient bits per cycle.
// Depends on grc_pkg for the operand widths.
`default_nettype none

module grc_div
  import grc_pkg::*;
(
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  input  wire logic [DVW-1:0] dividend,
  input  wire logic [DSW-1:0] divisor,
  output logic                done,
  output logic [DVW-1:0]      quotient
);

  localparam int STEPS = DVW / 2;
  localparam int NW    = $clog2(STEPS + 1);

  logic [DSW:0]   rem;
  logic [DVW-1:0] quo;
  logic [DSW-1:0] dsor;
  logic [NW-1:0]  cnt;
  logic           running;
  logic [DSW:0]   rem_next;
  logic [DVW-1:0] quo_next;

  always_comb begin
    rem_next = rem;
    quo_next = quo;
    for (int i = 0; i < 2; i++) begin
      rem_next = {rem_next[DSW-1:0], quo_next[DVW-1]};
      quo_next = {quo_next[DVW-2:0], 1'b0};
      if (rem_next >= {1'b0, dsor}) begin
        rem_next    = rem_next - {1'b0, dsor};
        quo_next[0] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= NW'(STEPS);
        rem     <= '0;
        quo     <= dividend;
        dsor    <= divisor;
      end else if (running) begin
        rem <= rem_next;
        quo <= quo_next;
        cnt <= cnt - 1'b1;
        if (cnt == NW'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  assign quotient = quo;

endmodule

`default_nettype wire

// File: src/grc_dp.sv
// grc_dp: datapath of the ray caster: pose, trig, grid walk, distance and height.
// Depends on grc_pkg and instantiates grc_div; driven by commands from grc_ctrl.
`default_nettype none

module grc_dp
  import grc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [16:0] viewer_x,
  input  wire logic [16:0] viewer_y,
  input  wire logic [8:0]  heading,
  input  wire logic        cfg_valid,
  input  wire logic [63:0] cfg_data,
  input  wire ctl_t        ctl,
  output stat_t            stat,
  output logic             result_valid,
  output logic [5:0]       column,
  output logic [8:0]       wall_height,
  output logic [7:0]       wall_top,
  output logic             vertical_side,
  output logic             last_column
);

  localparam pos_t  TILE_P    = pos_t'(TILE);
  localparam pos_t  NO_HIT_P  = pos_t'(NO_HIT_DIST);
  localparam trig_t EPS_P     = trig_t'(AXIS_EPS);
  localparam logic [8:0] VH_P = 9'(VIEW_HEIGHT);

  logic [63:0]   wall_map;
  logic [16:0]   vx, vy;
  logic [8:0]    hd, angle;
  logic [RW-1:0] ray_counter;
  trig_t         s_val, c_val, c_corr;
  tan_t          tan_v, cot_v;
  pos_t          probe_x, probe_y, advance_x, advance_y;
  logic [CW-1:0] crossing_count;
  pos_t          vertical_distance, hdist, ray_dist, cdist;
  logic          vside;
  prod_t         prod_a, prod_b;
  logic [8:0]    height;
  phase_t        walk_phase;

  logic [8:0]     hd_in;
  logic [9:0]     ang_sum, corr_sum;
  logic [8:0]     angle_init, corr;
  pos_t           vx_s, vy_s, base_x, base_y;
  logic [15:0]    abs_s, abs_c;
  logic           div_start;
  logic [DVW-1:0] div_num;
  logic [DSW-1:0] div_den;
  logic           div_done;
  logic [DVW-1:0] quo;
  tan_t           ratio_sat;
  logic [19:0]    ratio_mag;
  logic           cell_in;
  logic [5:0]     cell_idx;
  logic           wall_now;

  // pose and angle arithmetic
  always_comb begin
    hd_in = (heading >= 9'd360) ? heading - 9'd360 : heading;
    ang_sum = {1'b0, hd_in} + 10'(HALF_FOV);
    angle_init = (ang_sum >= 10'd360) ? 9'(ang_sum - 10'd360) : ang_sum[8:0];
    corr_sum = {1'b0, hd} + 10'd360 - {1'b0, angle};
    corr = (corr_sum >= 10'd360) ? 9'(corr_sum - 10'd360) : corr_sum[8:0];
  end

  assign vx_s   = $signed({{(PW-17){1'b0}}, vx});
  assign vy_s   = $signed({{(PW-17){1'b0}}, vy});
  assign base_x = $signed({{(PW-17){1'b0}}, vx[16:14], 14'd0});
  assign base_y = $signed({{(PW-17){1'b0}}, vy[16:14], 14'd0});
  assign abs_s  = s_val[15] ? 16'(-s_val) : 16'(s_val);
  assign abs_c  = c_val[15] ? 16'(-c_val) : 16'(c_val);

  // divider operand selection
  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    unique case (ctl.cmd)
      CMD_DIV_TAN: begin
        div_start = 1'b1;
        div_num   = DVW'({abs_s, 14'd0}) + DVW'(abs_c >> 1);
        div_den   = DSW'(abs_c);
      end
      CMD_DIV_COT: begin
        div_start = 1'b1;
        div_num   = DVW'({abs_c, 14'd0}) + DVW'(abs_s >> 1);
        div_den   = DSW'(abs_s);
      end
      CMD_DIV_H: begin
        div_start = 1'b1;
        div_num   = DVW'(HEIGHT_NUM);
        div_den   = cdist[DSW-1:0];
      end
      default: begin
      end
    endcase
  end

  grc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (div_den),
    .done     (div_done),
    .quotient (quo)
  );

  // saturated magnitude of the last ratio
  assign ratio_mag = (quo > DVW'(TAN_LIMIT)) ? 20'(TAN_LIMIT) : quo[19:0];
  assign ratio_sat = $signed({2'b00, ratio_mag});

  // wall lookup at the current probe; outside the map never hits
  always_comb begin
    cell_in  = !probe_x[PW-1] && !probe_y[PW-1]
            && (probe_x[PW-2:14] < (PW-15)'(MAP_SIDE))
            && (probe_y[PW-2:14] < (PW-15)'(MAP_SIDE));
    cell_idx = 6'(probe_y[PW-2:14] * (PW-15)'(MAP_SIDE) + probe_x[PW-2:14]);
    wall_now = cell_in && wall_map[cell_idx];
  end

  always_comb begin
    stat.v_en      = (c_val > EPS_P) || (c_val < -EPS_P);
    stat.h_en      = (s_val > EPS_P) || (s_val < -EPS_P);
    stat.wall      = wall_now;
    stat.walk_done = (crossing_count == CW'(MAX_CROSSINGS));
    stat.horz      = (walk_phase == PH_HORZ);
    stat.div_done  = div_done;
    stat.cdist_pos = (cdist > pos_t'(0));
    stat.last_ray  = (ray_counter == RW'(NUM_RAYS - 1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wall_map     <= '0;
      result_valid <= 1'b0;
      walk_phase   <= PH_IDLE;
      ray_counter  <= '0;
      angle        <= '0;
    end else begin
      result_valid <= 1'b0;
      if (cfg_valid) wall_map <= cfg_data;
      unique case (ctl.cmd)
        CMD_LOAD: begin
          vx          <= viewer_x;
          vy          <= viewer_y;
          hd          <= hd_in;
          angle       <= angle_init;
          ray_counter <= '0;
          walk_phase  <= PH_IDLE;
        end
        CMD_TRIG: begin
          s_val             <= sin_q14(angle);
          c_val             <= cos_q14(angle);
          c_corr            <= cos_q14(corr);
          vertical_distance <= NO_HIT_P;
          hdist             <= NO_HIT_P;
        end
        CMD_SAVE_TAN: tan_v <= (s_val[15] != c_val[15]) ? -ratio_sat : ratio_sat;
        CMD_SAVE_COT: cot_v <= (s_val[15] != c_val[15]) ? -ratio_sat : ratio_sat;
        CMD_VINIT: begin
          probe_x        <= (c_val > EPS_P) ? base_x + TILE_P : base_x - pos_t'(1);
          advance_x      <= (c_val > EPS_P) ? TILE_P : -TILE_P;
          crossing_count <= '0;
          walk_phase     <= PH_VERT;
        end
        CMD_VMUL_POS: prod_a <= (vx_s - probe_x) * tan_v;
        CMD_VSET_POS: probe_y <= vy_s + q14_round(prod_a);
        CMD_VMUL_ADV: prod_a <= (-advance_x) * tan_v;
        CMD_VSET_ADV: advance_y <= q14_round(prod_a);
        CMD_HINIT: begin
          probe_y        <= (s_val > EPS_P) ? base_y - pos_t'(1) : base_y + TILE_P;
          advance_y      <= (s_val > EPS_P) ? -TILE_P : TILE_P;
          crossing_count <= '0;
          walk_phase     <= PH_HORZ;
        end
        CMD_HMUL_POS: prod_a <= (vy_s - probe_y) * cot_v;
        CMD_HSET_POS: probe_x <= vx_s + q14_round(prod_a);
        CMD_HMUL_ADV: prod_a <= (-advance_y) * cot_v;
        CMD_HSET_ADV: advance_x <= q14_round(prod_a);
        CMD_STEP: begin
          probe_x        <= probe_x + advance_x;
          probe_y        <= probe_y + advance_y;
          crossing_count <= crossing_count + 1'b1;
        end
        CMD_DMUL_C: prod_a <= c_val * (probe_x - vx_s);
        CMD_DMUL_S: prod_b <= s_val * (probe_y - vy_s);
        CMD_DSET: begin
          if (walk_phase == PH_HORZ) hdist <= q14_round(prod_a - prod_b);
          else vertical_distance <= q14_round(prod_a - prod_b);
        end
        CMD_SELECT: begin
          vside    <= (vertical_distance < hdist);
          ray_dist <= (vertical_distance < hdist) ? vertical_distance : hdist;
        end
        CMD_CMUL: prod_a <= ray_dist * c_corr;
        CMD_CSET: cdist <= q14_round(prod_a);
        CMD_SET_H: begin
          if (cdist > pos_t'(0) && quo < DVW'(VIEW_HEIGHT)) height <= quo[8:0];
          else height <= VH_P;
        end
        CMD_EMIT: begin
          result_valid  <= 1'b1;
          column        <= ray_counter;
          wall_height   <= height;
          wall_top      <= 8'(VH_P >> 1) - 8'(height >> 1);
          vertical_side <= vside;
          last_column   <= (ray_counter == RW'(NUM_RAYS - 1));
          angle         <= (angle == 9'd0) ? 9'd359 : angle - 9'd1;
          ray_counter   <= ray_counter + 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: src/grc_ctrl.sv
// grc_ctrl: sequencer that steps the datapath through each ray of a frame.
// Depends on grc_pkg for command codes and the status struct.
`default_nettype none

module grc_ctrl
  import grc_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  start,
  input  wire stat_t stat,
  output logic       busy,
  output ctl_t       ctl
);

  typedef enum logic [4:0] {
    S_IDLE, S_TRIG, S_TAN_GO, S_TAN_WAIT, S_COT_GO, S_COT_WAIT,
    S_VINIT, S_VMP, S_VSP, S_VMA, S_VSA,
    S_HINIT, S_HMP, S_HSP, S_HMA, S_HSA,
    S_WALK, S_DMS, S_DSET,
    S_SEL, S_CMUL, S_CSET, S_HGO, S_HWAIT, S_EMIT
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    ctl.cmd    = CMD_NONE;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          ctl.cmd    = CMD_LOAD;
          state_next = S_TRIG;
        end
      end
      S_TRIG: begin
        ctl.cmd    = CMD_TRIG;
        state_next = S_TAN_GO;
      end
      S_TAN_GO: begin
        if (stat.v_en) begin
          ctl.cmd    = CMD_DIV_TAN;
          state_next = S_TAN_WAIT;
        end else state_next = S_COT_GO;
      end
      S_TAN_WAIT: begin
        if (stat.div_done) begin
          ctl.cmd    = CMD_SAVE_TAN;
          state_next = S_COT_GO;
        end
      end
      S_COT_GO: begin
        if (stat.h_en) begin
          ctl.cmd    = CMD_DIV_COT;
          state_next = S_COT_WAIT;
        end else state_next = S_VINIT;
      end
      S_COT_WAIT: begin
        if (stat.div_done) begin
          ctl.cmd    = CMD_SAVE_COT;
          state_next = S_VINIT;
        end
      end
      S_VINIT: begin
        if (stat.v_en) begin
          ctl.cmd    = CMD_VINIT;
          state_next = S_VMP;
        end else state_next = S_HINIT;
      end
      S_VMP: begin
        ctl.cmd    = CMD_VMUL_POS;
        state_next = S_VSP;
      end
      S_VSP: begin
        ctl.cmd    = CMD_VSET_POS;
        state_next = S_VMA;
      end
      S_VMA: begin
        ctl.cmd    = CMD_VMUL_ADV;
        state_next = S_VSA;
      end
      S_VSA: begin
        ctl.cmd    = CMD_VSET_ADV;
        state_next = S_WALK;
      end
      S_HINIT: begin
        if (stat.h_en) begin
          ctl.cmd    = CMD_HINIT;
          state_next = S_HMP;
        end else state_next = S_SEL;
      end
      S_HMP: begin
        ctl.cmd    = CMD_HMUL_POS;
        state_next = S_HSP;
      end
      S_HSP: begin
        ctl.cmd    = CMD_HSET_POS;
        state_next = S_HMA;
      end
      S_HMA: begin
        ctl.cmd    = CMD_HMUL_ADV;
        state_next = S_HSA;
      end
      S_HSA: begin
        ctl.cmd    = CMD_HSET_ADV;
        state_next = S_WALK;
      end
      S_WALK: begin
        priority if (stat.walk_done) begin
          state_next = stat.horz ? S_SEL : S_HINIT;
        end else if (stat.wall) begin
          ctl.cmd    = CMD_DMUL_C;
          state_next = S_DMS;
        end else begin
          ctl.cmd = CMD_STEP;
        end
      end
      S_DMS: begin
        ctl.cmd    = CMD_DMUL_S;
        state_next = S_DSET;
      end
      S_DSET: begin
        ctl.cmd    = CMD_DSET;
        state_next = stat.horz ? S_SEL : S_HINIT;
      end
      S_SEL: begin
        ctl.cmd    = CMD_SELECT;
        state_next = S_CMUL;
      end
      S_CMUL: begin
        ctl.cmd    = CMD_CMUL;
        state_next = S_CSET;
      end
      S_CSET: begin
        ctl.cmd    = CMD_CSET;
        state_next = S_HGO;
      end
      S_HGO: begin
        if (stat.cdist_pos) begin
          ctl.cmd    = CMD_DIV_H;
          state_next = S_HWAIT;
        end else begin
          ctl.cmd    = CMD_SET_H;
          state_next = S_EMIT;
        end
      end
      S_HWAIT: begin
        if (stat.div_done) begin
          ctl.cmd    = CMD_SET_H;
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        ctl.cmd    = CMD_EMIT;
        state_next = stat.last_ray ? S_IDLE : S_TRIG;
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

`default_nettype wire

// File: src/grid_raycast_wall_columns.sv
// grid_raycast_wall_columns: top level of the grid ray caster, wall-column stage.
// Depends on grc_pkg; instantiates grc_ctrl and grc_dp.
//
// Usage:
//   A viewer pose (viewer_x, viewer_y, heading) is taken at a clock edge where
//   start is high and busy is low. busy then stays high while the frame's 60
//   rays are cast; one result per ray appears on column, wall_height, wall_top,
//   vertical_side and last_column, marked by result_valid for a single cycle.
//   last_column flags the final ray; busy drops in the cycle it is shown.
//   The receiver cannot stall and must take each result when it is shown.
//   The user must write wall_map through cfg_valid/cfg_ready/cfg_data only
//   while idle; the block itself does not enforce it. cfg_ready is always high.
// Per ray:
//   each ray runs three divisions on the shared two-bits-per-cycle divider
//   (tangent, cotangent, wall height), two grid walks and the multiply steps.
//   A near-axis ray skips a walk and a division, and a distance of zero or
//   less skips the height division.
// Reset:
//   synchronous rst returns the sequencer to idle, clears the wall map and
//   drops result_valid.
`default_nettype none

module grid_raycast_wall_columns
  import grc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [16:0] viewer_x,
  input  wire logic [16:0] viewer_y,
  input  wire logic [8:0]  heading,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [63:0] cfg_data,
  output logic             result_valid,
  output logic [5:0]       column,
  output logic [8:0]       wall_height,
  output logic [7:0]       wall_top,
  output logic             vertical_side,
  output logic             last_column
);

  ctl_t  ctl;
  stat_t stat;

  assign cfg_ready = 1'b1;

  grc_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .busy  (busy),
    .ctl   (ctl)
  );

  grc_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .viewer_x      (viewer_x),
    .viewer_y      (viewer_y),
    .heading       (heading),
    .cfg_valid     (cfg_valid),
    .cfg_data      (cfg_data),
    .ctl           (ctl),
    .stat          (stat),
    .result_valid  (result_valid),
    .column        (column),
    .wall_height   (wall_height),
    .wall_top      (wall_top),
    .vertical_side (vertical_side),
    .last_column   (last_column)
  );

endmodule

`default_nettype wire

// File: src/grc_checker.sv
// grc_checker: port-level checks on the ray caster's result stream and handshake.
// Depends on grc_pkg; bound to grid_raycast_wall_columns below.
`default_nettype none

module grc_checker
  import grc_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       start,
  input wire logic       busy,
  input wire logic       result_valid,
  input wire logic [5:0] column,
  input wire logic [8:0] wall_height,
  input wire logic [7:0] wall_top,
  input wire logic       last_column
);

  // a frame stays open until its last item is shown
  a_busy_mid_frame: assert property (@(posedge clk) disable iff (rst)
    result_valid && !last_column |-> busy)
    else $error("result shown outside an open frame");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted pose did not open a frame");

  a_height_top: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (wall_height <= 9'(VIEW_HEIGHT))
                 && (wall_top == 8'(VIEW_HEIGHT / 2) - 8'(wall_height >> 1)))
    else $error("height or top out of relation");

  a_last_index: assert property (@(posedge clk) disable iff (rst)
    result_valid && last_column |-> column == 6'(NUM_RAYS - 1))
    else $error("last item has wrong column");

  a_strobe_gap: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid)
    else $error("back to back result strobes");

endmodule

bind grid_raycast_wall_columns grc_checker u_grc_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .result_valid (result_valid),
  .column       (column),
  .wall_height  (wall_height),
  .wall_top     (wall_top),
  .last_column  (last_column)
);

`default_nettype wire

// File: tb/grc_frame_checker.sv
// grc_frame_checker: watches the pose, config and result channels of the ray caster,
// predicts the 60 wall columns of each accepted pose and compares them in order.
// Depends on grc_pkg for sizes, fixed-point constants and the quarter sine table.
`default_nettype none

module grc_frame_checker
  import grc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic        busy,
  input  wire logic [16:0] viewer_x,
  input  wire logic [16:0] viewer_y,
  input  wire logic [8:0]  heading,
  input  wire logic        cfg_valid,
  input  wire logic        cfg_ready,
  input  wire logic [63:0] cfg_data,
  input  wire logic        result_valid,
  input  wire logic [5:0]  column,
  input  wire logic [8:0]  wall_height,
  input  wire logic [7:0]  wall_top,
  input  wire logic        vertical_side,
  input  wire logic        last_column,
  output int               fail_count,
  output int               pending,
  output int               poses_seen,
  output int               columns_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [5:0] column;
    logic [8:0] height;
    logic [7:0] top;
    logic       vside;
    logic       last;
  } slice_t;

  slice_t     slice_q[$];
  logic [63:0] map_bits;
  longint     sin_lut[360];
  longint     cos_lut[360];
  longint     tan_lut[360];
  longint     cot_lut[360];

  assign pending = slice_q.size();

  function automatic longint sat_ratio(longint num, longint den);
    longint n, d, q;
    logic   neg;
    n = (num < 0) ? -num : num;
    d = (den < 0) ? -den : den;
    neg = (num < 0) != (den < 0);
    if (d == 0) begin
      q = TAN_LIMIT;
      neg = num < 0;
    end else begin
      q = (n * 16384 + d / 2) / d;
      if (q > TAN_LIMIT) q = TAN_LIMIT;
    end
    return neg ? -q : q;
  endfunction

  initial begin
    for (int d = 0; d < 360; d++) begin
      if (d <= 90) sin_lut[d] = SIN_Q[d];
      else if (d <= 180) sin_lut[d] = SIN_Q[180 - d];
      else if (d <= 270) sin_lut[d] = -longint'(SIN_Q[d - 180]);
      else sin_lut[d] = -longint'(SIN_Q[360 - d]);
    end
    for (int d = 0; d < 360; d++) cos_lut[d] = sin_lut[(d + 90) % 360];
    for (int d = 0; d < 360; d++) begin
      tan_lut[d] = sat_ratio(sin_lut[d], cos_lut[d]);
      cot_lut[d] = sat_ratio(cos_lut[d], sin_lut[d]);
    end
  end

  // floor((p + 8192) / 16384)
  function automatic longint q14r(longint p);
    return (p + 8192) >>> 14;
  endfunction

  // off-map and negative probes are never walls
  function automatic logic wall_at(longint x, longint y);
    longint cx, cy;
    if (x < 0 || y < 0) return 1'b0;
    cx = x / TILE;
    cy = y / TILE;
    if (cx >= MAP_SIDE || cy >= MAP_SIDE) return 1'b0;
    return map_bits[cy * MAP_SIDE + cx];
  endfunction

  function automatic longint grid_walk(longint px, longint py, longint ax, longint ay,
                                       longint c, longint s, longint vx, longint vy);
    for (int k = 0; k < MAX_CROSSINGS; k++) begin
      if (wall_at(px, py)) return q14r(c * (px - vx) - s * (py - vy));
      px += ax;
      py += ay;
    end
    return NO_HIT_DIST;
  endfunction

  function automatic void cast_frame(longint vx, longint vy, int hd);
    int     a, corr;
    longint c, s, base, px, py, ax, ay, vdist, hdist, ray_dist, h;
    logic   vside;
    slice_t sl;
    if (hd >= 360) hd -= 360;
    a = (hd + HALF_FOV) % 360;
    for (int r = 0; r < NUM_RAYS; r++) begin
      c = cos_lut[a];
      s = sin_lut[a];
      vdist = NO_HIT_DIST;
      base = (vx / TILE) * TILE;
      if (c > AXIS_EPS || c < -AXIS_EPS) begin
        px = (c > AXIS_EPS) ? base + TILE : base - 1;
        ax = (c > AXIS_EPS) ? TILE : -TILE;
        py = vy + q14r((vx - px) * tan_lut[a]);
        ay = q14r(-ax * tan_lut[a]);
        vdist = grid_walk(px, py, ax, ay, c, s, vx, vy);
      end
      hdist = NO_HIT_DIST;
      base = (vy / TILE) * TILE;
      if (s > AXIS_EPS || s < -AXIS_EPS) begin
        py = (s > AXIS_EPS) ? base - 1 : base + TILE;
        ay = (s > AXIS_EPS) ? -TILE : TILE;
        px = vx + q14r((vy - py) * cot_lut[a]);
        ax = q14r(-ay * cot_lut[a]);
        hdist = grid_walk(px, py, ax, ay, c, s, vx, vy);
      end
      // ties go to the horizontal side
      vside = vdist < hdist;
      ray_dist = vside ? vdist : hdist;
      corr = (hd + 360 - a) % 360;
      ray_dist = q14r(ray_dist * cos_lut[corr]);
      if (ray_dist <= 0) h = VIEW_HEIGHT;
      else begin
        h = HEIGHT_NUM / ray_dist;
        if (h > VIEW_HEIGHT) h = VIEW_HEIGHT;
      end
      sl.column = 6'(r);
      sl.height = 9'(h);
      sl.top    = 8'(VIEW_HEIGHT / 2 - h / 2);
      sl.vside  = vside;
      sl.last   = (r == NUM_RAYS - 1);
      slice_q.push_back(sl);
      a = (a == 0) ? 359 : a - 1;
    end
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    poses_seen = 0;
    columns_seen = 0;
    map_bits = '0;
  end

  always @(posedge clk) begin
    slice_t want;
    if (rst) begin
      map_bits = '0;
    end else begin
      if (cfg_valid && cfg_ready) map_bits = cfg_data;
      if (start && !busy) begin
        cast_frame(viewer_x, viewer_y, heading);
        poses_seen++;
      end
      if (result_valid) begin
        columns_seen++;
        if (slice_q.size() == 0) begin
          report("column with nothing expected", column, -1);
        end else begin
          want = slice_q.pop_front();
          if (column !== want.column) report("column", column, want.column);
          if (wall_height !== want.height) report("wall_height", wall_height, want.height);
          if (wall_top !== want.top) report("wall_top", wall_top, want.top);
          if (vertical_side !== want.vside) report("vertical_side", vertical_side, want.vside);
          if (last_column !== want.last) report("last_column", last_column, want.last);
        end
      end
    end
  end

endmodule

`default_nettype wire

// File: tb/grid_raycast_wall_columns_test.sv
// grid_raycast_wall_columns_test: drives poses and wall maps into the ray caster
// and gives the verdict. Depends on grc_pkg, the block and grc_frame_checker.
`default_nettype none

module grid_raycast_wall_columns_test;
  import grc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [16:0] viewer_x = '0;
  logic [16:0] viewer_y = '0;
  logic [8:0]  heading = '0;
  logic        cfg_valid = 1'b0;
  logic [63:0] cfg_data = '0;
  logic        busy, cfg_ready, result_valid, vertical_side, last_column;
  logic [5:0]  column;
  logic [8:0]  wall_height;
  logic [7:0]  wall_top;
  int          fail_count, pending, poses_seen, columns_seen;
  int          calm;

  grid_raycast_wall_columns u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .viewer_x(viewer_x), .viewer_y(viewer_y), .heading(heading),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .result_valid(result_valid), .column(column), .wall_height(wall_height),
    .wall_top(wall_top), .vertical_side(vertical_side), .last_column(last_column)
  );

  grc_frame_checker u_check (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .viewer_x(viewer_x), .viewer_y(viewer_y), .heading(heading),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .result_valid(result_valid), .column(column), .wall_height(wall_height),
    .wall_top(wall_top), .vertical_side(vertical_side), .last_column(last_column),
    .fail_count(fail_count), .pending(pending), .poses_seen(poses_seen),
    .columns_seen(columns_seen)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #(100_000_000);
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic send_pose(logic [16:0] x, logic [16:0] y, logic [8:0] hd);
    int gap;
    viewer_x <= x;
    viewer_y <= y;
    heading  <= hd;
    start    <= 1'b1;
    do @(posedge clk); while (busy);
    gap = calm ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // waits until nothing is in flight before writing the map
  task automatic load_map(logic [63:0] bits);
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);
    repeat (20) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= bits;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [63:0] rand_map();
    logic [63:0] m;
    m = {$urandom(), $urandom()};
    case ($urandom_range(0, 2))
      0: m = m & {$urandom(), $urandom()};
      1: m = m | {$urandom(), $urandom()};
      default: ;
    endcase
    return m;
  endfunction

  initial begin
    calm = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty map: every ray misses
    load_map(64'h0);
    send_pose(17'd0, 17'd0, 9'd0);
    send_pose(17'h1FFFF, 17'h1FFFF, 9'd90);
    send_pose(17'd65536, 17'd65536, 9'd359);
    // solid map, viewer inside a wall
    load_map({64{1'b1}});
    send_pose(17'd0, 17'd0, 9'd180);
    send_pose(17'd70000, 17'd40000, 9'd270);
    send_pose(17'h1FFFF, 17'd0, 9'd511);
    // only cell zero is a wall
    load_map(64'h1);
    send_pose(17'd40000, 17'd40000, 9'd225);
    send_pose(17'd20000, 17'd60000, 9'd270);
    send_pose(17'd60000, 17'd20000, 9'd180);
    // border ring, axis headings and out-of-range headings
    load_map(64'hFF81_8181_8181_81FF);
    send_pose(17'd65536, 17'd65536, 9'd0);
    send_pose(17'd65536, 17'd65536, 9'd90);
    send_pose(17'd65536, 17'd65536, 9'd180);
    send_pose(17'd65536, 17'd65536, 9'd270);
    send_pose(17'd65536, 17'd65536, 9'd360);
    send_pose(17'd65536, 17'd65536, 9'd450);
    send_pose(17'd32768, 17'd32768, 9'd45);
    send_pose(17'd16384, 17'd98304, 9'd135);
    load_map(64'hFFFF_FFFF_FFFF_FFFE);
    send_pose(17'd8192, 17'd8192, 9'd300);

    for (int ph = 0; ph < 6; ph++) begin
      load_map(rand_map());
      for (int i = 0; i < 32; i++) begin
        calm = (ph == 2);
        if (ph == 4 && i == 10) begin
          start <= 1'b0;
          @(posedge clk);
          while (pending != 0) @(posedge clk);
        end
        send_pose(17'($urandom()), 17'($urandom()),
                  ($urandom_range(0, 9) == 0) ? 9'($urandom_range(360, 511))
                                              : 9'($urandom_range(0, 359)));
      end
    end
    calm = 0;
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);
    repeat (200) @(posedge clk);

    $display("covered %0d poses over 11 wall maps, %0d wall columns compared",
             poses_seen, columns_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire
